### hw/rtl/snlm_pkg.sv
// shared types, constants and microcode table for the sorted name list merge
package snlm_pkg;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned NAME_W = 72;

  localparam logic [1:0] OP_LOAD_A = 2'd0;
  localparam logic [1:0] OP_LOAD_B = 2'd1;
  localparam logic [1:0] OP_MERGE  = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] name_head;
    logic [7:0]  name_tail;
  } in_req_t;

  typedef struct packed {
    logic [63:0] out_head;
    logic [7:0]  out_tail;
    logic        from_list_b;
    logic        last;
  } out_res_t;

  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_READ,
    STEP_EMIT
  } step_t;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_MERGE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  do_read;
    logic  emit;
    cond_t cond;
    step_t target;
  } ctl_word_t;

  typedef struct packed {
    logic merge_req;
    logic out_free;
    logic last_name;
  } seq_status_t;

  // microcode rom: one control word per step
  function automatic ctl_word_t ucode(step_t step);
    ctl_word_t w;
    w = '{take_in: 1'b0, do_read: 1'b0, emit: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: w = '{take_in: 1'b1, do_read: 1'b0, emit: 1'b0,
                       cond: COND_MERGE, target: STEP_READ};
      STEP_READ: w = '{take_in: 1'b0, do_read: 1'b1, emit: 1'b0,
                       cond: COND_ALWAYS, target: STEP_EMIT};
      STEP_EMIT: w = '{take_in: 1'b0, do_read: 1'b0, emit: 1'b1,
                       cond: COND_OUT_FREE, target: STEP_READ};
      default:   w = '{take_in: 1'b0, do_read: 1'b0, emit: 1'b0,
                       cond: COND_ALWAYS, target: STEP_IDLE};
    endcase
    return w;
  endfunction

  // strcmp order: true if x sorts strictly after y
  function automatic logic name_after(logic [NAME_W-1:0] x, logic [NAME_W-1:0] y);
    logic [NAME_W-1:0] xm;
    logic [NAME_W-1:0] ym;
    logic              alive;
    xm = '0;
    ym = '0;
    alive = 1'b1;
    for (int i = 0; i < 9; i++) begin
      // bytes past the first zero of x take no part
      if (alive) begin
        xm[NAME_W-1-8*i -: 8] = x[NAME_W-1-8*i -: 8];
        ym[NAME_W-1-8*i -: 8] = y[NAME_W-1-8*i -: 8];
      end
      alive = alive & (x[NAME_W-1-8*i -: 8] != 8'd0);
    end
    return xm > ym;
  endfunction

endpackage

### hw/rtl/snlm_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
module snlm_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  snlm_pkg::seq_status_t status,
  output snlm_pkg::ctl_word_t   ctl,
  output snlm_pkg::step_t       step
);
  import snlm_pkg::*;

  step_t step_r;
  step_t step_nxt;
  logic  cond_met;

  always_comb begin
    ctl  = ucode(step_r);
    step = step_r;
  end

  always_comb begin
    unique case (ctl.cond)
      COND_ALWAYS:   cond_met = 1'b1;
      COND_MERGE:    cond_met = status.merge_req;
      COND_OUT_FREE: cond_met = status.out_free;
      default:       cond_met = 1'b0;
    endcase
    step_nxt = step_r;
    if (cond_met) begin
      // the final emit returns to idle instead of fetching again
      if (ctl.emit && status.last_name) begin
        step_nxt = STEP_IDLE;
      end else begin
        step_nxt = ctl.target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### hw/rtl/sorted_name_list_merge.sv
// sorted name list merge: top level with list stores and merge datapath
// Input channel (in_valid / in_stall / in_data) carries one request per item:
// opcode 0 appends the name to list A, opcode 1 to list B, opcode 2 merges.
// A load gives no result; a load into a full list
// is dropped. A merge with both lists empty gives no result.
// A merge request emits every stored name on the output channel
// (out_valid / out_stall / out_data) in ascending byte order, list A first
// on a tie, with last set on the final name; both lists are then empty.
// Each name passes a read step, which fetches both list heads from their
// stores, and an emit step, which compares them and registers the result.
// The first result is registered in the emit step that follows the first
// read step, and in_stall stays high until the final name is registered.
// The result register is freed in the cycle it is taken, so a stalled
// receiver holds the merge on its compare step without losing a name.
// Reset holds in_stall high, empties both lists and idles the sequencer;
// list contents are not cleared, only the fill counts.
module sorted_name_list_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  snlm_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output snlm_pkg::out_res_t out_data
);
  import snlm_pkg::*;

  logic [NAME_W-1:0] mem_a [LIST_DEPTH];
  logic [NAME_W-1:0] mem_b [LIST_DEPTH];

  logic [CNT_W-1:0]  cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0]  cnt_b_r, cnt_b_nxt;
  logic [CNT_W-1:0]  ia_r, ia_nxt;
  logic [CNT_W-1:0]  ib_r, ib_nxt;
  logic [NAME_W-1:0] rd_a_r;
  logic [NAME_W-1:0] rd_b_r;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_data_r, out_data_nxt;

  ctl_word_t         ctl;
  step_t             step;
  seq_status_t       status;

  logic              in_fire;
  logic              load_a;
  logic              load_b;
  logic              out_free;
  logic              emit_fire;
  logic              a_left;
  logic              b_left;
  logic              take_b;
  logic [CNT_W:0]    remaining;
  logic              last_name;
  logic [NAME_W-1:0] pick;

  snlm_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctl    (ctl),
    .step   (step)
  );

  assign in_stall  = !ctl.take_in || !rst_n;
  assign in_fire   = in_valid && !in_stall;
  assign load_a    = in_fire && (in_data.opcode == OP_LOAD_A) && (cnt_a_r < CNT_W'(LIST_DEPTH));
  assign load_b    = in_fire && (in_data.opcode == OP_LOAD_B) && (cnt_b_r < CNT_W'(LIST_DEPTH));
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = ctl.emit && out_free;

  always_comb begin
    a_left    = ia_r < cnt_a_r;
    b_left    = ib_r < cnt_b_r;
    take_b    = !a_left || (b_left && name_after(rd_a_r, rd_b_r));
    remaining = {1'b0, cnt_a_r - ia_r} + {1'b0, cnt_b_r - ib_r};
    last_name = (remaining == (CNT_W + 1)'(1));
    pick      = take_b ? rd_b_r : rd_a_r;
  end

  always_comb begin
    status.merge_req = in_fire && (in_data.opcode == OP_MERGE)
                       && ((cnt_a_r != '0) || (cnt_b_r != '0));
    status.out_free  = out_free;
    status.last_name = last_name;
  end

  always_comb begin
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (load_a) begin
      cnt_a_nxt = cnt_a_r + CNT_W'(1);
    end
    if (load_b) begin
      cnt_b_nxt = cnt_b_r + CNT_W'(1);
    end
    if (emit_fire) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.out_head    = pick[NAME_W-1 -: 64];
      out_data_nxt.out_tail    = pick[7:0];
      out_data_nxt.from_list_b = take_b;
      out_data_nxt.last        = last_name;
      if (last_name) begin
        cnt_a_nxt = '0;
        cnt_b_nxt = '0;
        ia_nxt    = '0;
        ib_nxt    = '0;
      end else if (take_b) begin
        ib_nxt = ib_r + CNT_W'(1);
      end else begin
        ia_nxt = ia_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      ia_r        <= '0;
      ib_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      ia_r        <= ia_nxt;
      ib_r        <= ib_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // list stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (load_a) begin
      mem_a[cnt_a_r[IDX_W-1:0]] <= {in_data.name_head, in_data.name_tail};
    end
    if (ctl.do_read) begin
      rd_a_r <= mem_a[ia_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (load_b) begin
      mem_b[cnt_b_r[IDX_W-1:0]] <= {in_data.name_head, in_data.name_tail};
    end
    if (ctl.do_read) begin
      rd_b_r <= mem_b[ib_r[IDX_W-1:0]];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_W'(LIST_DEPTH)) && (cnt_b_r <= CNT_W'(LIST_DEPTH)))
    else $error("list fill count beyond depth");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ia_r <= cnt_a_r) && (ib_r <= cnt_b_r))
    else $error("merge index ran past list end");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && last_name) |=> (cnt_a_r == '0) && (cnt_b_r == '0) && (step == STEP_IDLE))
    else $error("lists not emptied after final name");

  a_merge_start: assert property (@(posedge clk) disable iff (!rst_n)
    status.merge_req |=> (step == STEP_READ) && in_stall)
    else $error("merge request did not start a read");

endmodule
